// ===== rtl/lfr_pkg.sv =====
// Shared types and constants for the LED frame receiver.
// Used by lfr_ctrl, lfr_dp and led_frame_receiver; depends on nothing.
package lfr_pkg;

  localparam int LED_SLOTS   = 255;
  localparam int STORE_BYTES = LED_SLOTS * 3;
  localparam int IDX_W       = $clog2(STORE_BYTES);

  localparam logic [IDX_W-1:0] STORE_LAST = IDX_W'(STORE_BYTES - 1);

  // Event codes carried in the func field.
  localparam logic [2:0] FUNC_BYTE   = 3'd0;
  localparam logic [2:0] FUNC_TICK   = 3'd1;
  localparam logic [2:0] FUNC_UPDATE = 3'd2;
  localparam logic [2:0] FUNC_BLANK  = 3'd3;
  localparam logic [2:0] FUNC_READ   = 3'd4;

  // Parser phases, as reported in parse_state.
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_GOT_R  = 3'd1;
  localparam logic [2:0] PH_GOT_G  = 3'd2;
  localparam logic [2:0] PH_TYPE   = 3'd3;
  localparam logic [2:0] PH_COLOUR = 3'd4;

  // Drive request codes.
  localparam logic [1:0] DRIVE_NONE  = 2'd0;
  localparam logic [1:0] DRIVE_STORE = 2'd1;
  localparam logic [1:0] DRIVE_DARK  = 2'd2;

  // Frame characters.
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_C = 8'h63;

  localparam logic [15:0] TIMEOUT_RESET = 16'd250;

  // Register index on the configuration port.
  localparam logic REG_TIMEOUT = 1'b0;
  localparam int   PADDR_W     = 3;

  typedef struct packed {
    logic [2:0]       func;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    logic [2:0] parse_state;
    logic       frame_loaded;
    logic       frame_done;
    logic       demo_request;
    logic [1:0] drive_request;
    logic [7:0] led_count;
    logic [7:0] read_data;
    logic       timed_out;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic clear_step;
    logic copy_step;
    logic read_cap;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_copy;
    logic need_read;
    logic clear_last;
    logic copy_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/lfr_ctrl.sv =====
// Sequencing state machine for the LED frame receiver.
// Depends on lfr_pkg; drives commands into lfr_dp and reads its status.
module lfr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  lfr_pkg::status_t status,
  output lfr_pkg::cmd_t    cmd
);
  import lfr_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_DRAIN,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t state;

  assign item_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (status.clear_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (item_valid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (status.need_copy) state <= ST_COPY;
          else if (status.need_read) state <= ST_READ;
          else state <= ST_EMIT;
        end
        ST_COPY: begin
          if (status.copy_last) state <= ST_DRAIN;
        end
        ST_DRAIN: state <= ST_EMIT;
        ST_READ:  state <= ST_EMIT;
        ST_EMIT: begin
          if (status.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == ST_IDLE) && item_valid;
    cmd.exec       = (state == ST_EXEC);
    cmd.clear_step = (state == ST_CLEAR);
    cmd.copy_step  = (state == ST_COPY);
    cmd.read_cap   = (state == ST_READ);
    cmd.emit       = (state == ST_EMIT) && status.out_free;
  end

endmodule

// ===== rtl/lfr_dp.sv =====
// Datapath of the LED frame receiver: parser registers, staging and
// display memories, configuration register and result register.
// Depends on lfr_pkg; sequenced by lfr_ctrl.
module lfr_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  lfr_pkg::cmd_t               cmd,
  output lfr_pkg::status_t            status,
  input  lfr_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output lfr_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata
);
  import lfr_pkg::*;

  // Configuration register.
  logic [15:0] timeout_ticks;

  // Parser state.
  logic [2:0]       phase, phase_next;
  logic             is_demo, is_demo_next;
  logic [7:0]       count_reg, count_next;
  logic [IDX_W-1:0] wr_ptr, wr_ptr_next;
  logic             ready_flag, ready_next;
  logic [15:0]      idle_ticks, idle_next;
  logic             timer_armed, timer_next;

  item_t            item_q;
  result_t          res, res_next;
  logic [IDX_W-1:0] copy_len, len_calc;
  logic             need_copy, need_read, stage_we;

  // Sweep address shared by the reset clear and the frame-end copy.
  logic [IDX_W-1:0] sweep_idx;
  logic             copy_wr_pend;
  logic [IDX_W-1:0] copy_wr_addr;

  logic [7:0] staging [STORE_BYTES];
  logic [7:0] display [STORE_BYTES];
  logic [7:0] stage_q, disp_q;

  logic             disp_we;
  logic [IDX_W-1:0] disp_waddr;
  logic [7:0]       disp_wdata;

  logic [7:0]  cnt_cap;
  logic [IDX_W-1:0] wp_inc;
  logic [15:0] tick_inc;

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TIMEOUT)) begin
      timeout_ticks <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (cmd.load) item_q <= item;
  end

  // Next parser state for the held item.
  always_comb begin
    phase_next   = phase;
    is_demo_next = is_demo;
    count_next   = count_reg;
    wr_ptr_next  = wr_ptr;
    ready_next   = ready_flag;
    idle_next    = idle_ticks;
    timer_next   = timer_armed;
    need_copy    = 1'b0;
    need_read    = 1'b0;
    stage_we     = 1'b0;
    res_next     = '0;
    cnt_cap      = (item_q.data_byte > 8'(LED_SLOTS)) ? 8'(LED_SLOTS) : item_q.data_byte;
    len_calc     = IDX_W'({count_reg, 1'b0}) + IDX_W'(count_reg);
    wp_inc       = wr_ptr + 1'b1;
    tick_inc     = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;

    case (item_q.func)
      FUNC_BYTE: begin
        case (phase)
          PH_IDLE: begin
            if (item_q.data_byte == CH_R) begin
              ready_next  = 1'b0;
              wr_ptr_next = '0;
              phase_next  = PH_GOT_R;
              timer_next  = 1'b1;
              idle_next   = '0;
            end
          end
          PH_GOT_R: begin
            timer_next = (item_q.data_byte == CH_G);
            idle_next  = '0;
            phase_next = (item_q.data_byte == CH_G) ? PH_GOT_G : PH_IDLE;
          end
          PH_GOT_G: begin
            idle_next = '0;
            if (item_q.data_byte == CH_B || item_q.data_byte == CH_C) begin
              is_demo_next = (item_q.data_byte == CH_C);
              phase_next   = PH_TYPE;
              timer_next   = 1'b1;
            end else begin
              phase_next = PH_IDLE;
              timer_next = 1'b0;
            end
          end
          PH_TYPE: begin
            count_next = cnt_cap;
            idle_next  = '0;
            if (is_demo) begin
              phase_next            = PH_IDLE;
              timer_next            = 1'b0;
              res_next.demo_request = 1'b1;
            end else if (cnt_cap == 8'd0) begin
              phase_next          = PH_IDLE;
              timer_next          = 1'b0;
              ready_next          = 1'b1;
              res_next.frame_done = 1'b1;
            end else begin
              phase_next = PH_COLOUR;
              timer_next = 1'b1;
            end
          end
          PH_COLOUR: begin
            stage_we    = (wr_ptr <= STORE_LAST);
            wr_ptr_next = wp_inc;
            timer_next  = 1'b1;
            idle_next   = '0;
            if (wp_inc >= len_calc) begin
              phase_next          = PH_IDLE;
              timer_next          = 1'b0;
              ready_next          = 1'b1;
              res_next.frame_done = 1'b1;
              need_copy           = 1'b1;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            timer_next = 1'b0;
            idle_next  = '0;
          end
        endcase
      end
      FUNC_TICK: begin
        if (timer_armed) begin
          idle_next = tick_inc;
          if (tick_inc >= timeout_ticks) begin
            wr_ptr_next        = '0;
            phase_next         = PH_IDLE;
            timer_next         = 1'b0;
            idle_next          = '0;
            res_next.timed_out = 1'b1;
          end
        end
      end
      FUNC_UPDATE: begin
        if (phase == PH_IDLE) begin
          res_next.drive_request = DRIVE_STORE;
          ready_next             = 1'b0;
        end
      end
      FUNC_BLANK: res_next.drive_request = DRIVE_DARK;
      FUNC_READ:  need_read = (item_q.read_index <= STORE_LAST);
      default: ;
    endcase

    res_next.parse_state  = phase_next;
    res_next.frame_loaded = ready_next;
    res_next.led_count    = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      is_demo     <= 1'b0;
      count_reg   <= 8'(LED_SLOTS);
      wr_ptr      <= '0;
      ready_flag  <= 1'b0;
      idle_ticks  <= '0;
      timer_armed <= 1'b0;
    end else if (cmd.exec) begin
      phase       <= phase_next;
      is_demo     <= is_demo_next;
      count_reg   <= count_next;
      wr_ptr      <= wr_ptr_next;
      ready_flag  <= ready_next;
      idle_ticks  <= idle_next;
      timer_armed <= timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res      <= res_next;
      copy_len <= len_calc;
    end else if (cmd.read_cap) begin
      res.read_data <= disp_q;
    end
  end

  // Sweep counter and the registered write strobe that delays the display write behind the staging read.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx    <= '0;
      copy_wr_pend <= 1'b0;
    end else begin
      copy_wr_pend <= cmd.copy_step;
      if (cmd.exec) sweep_idx <= '0;
      else if (cmd.clear_step || cmd.copy_step) sweep_idx <= sweep_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    copy_wr_addr <= sweep_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && stage_we) staging[wr_ptr] <= item_q.data_byte;
    stage_q <= staging[sweep_idx];
  end

  assign disp_we    = cmd.clear_step || copy_wr_pend;
  assign disp_waddr = cmd.clear_step ? sweep_idx : copy_wr_addr;
  assign disp_wdata = cmd.clear_step ? 8'd0 : stage_q;

  always_ff @(posedge clk) begin
    if (disp_we) display[disp_waddr] <= disp_wdata;
    disp_q <= display[item_q.read_index];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) result <= res;
  end

  always_comb begin
    status            = '0;
    status.need_copy  = need_copy;
    status.need_read  = need_read;
    status.clear_last = (sweep_idx == STORE_LAST);
    status.copy_last  = (sweep_idx == copy_len - 1'b1);
    status.out_free   = !result_valid || !result_stall;
  end

endmodule

// ===== rtl/led_frame_receiver.sv =====
// Top level of the LED frame receiver: serial frame parser with staged
// and displayed colour stores. Depends on lfr_pkg, lfr_ctrl and lfr_dp.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_stall      item (func, data_byte, read_index)
//   result    out        result_valid / result_stall  result (one per item)
//   config    in         APB psel/penable/pwrite      timeout_ticks at address 0
//
// A byte, tick, update or blank item passes from accept through ST_EXEC to ST_EMIT;
// a display read also passes ST_READ, as the display memory read port is registered.
// The byte that completes a colour frame also passes ST_COPY and ST_DRAIN,
// for the copy that walks 3*count staging entries into the display memory, one
// entry per cycle. After reset the display memory is cleared, all 765 entries,
// during which item_stall stays high; configuration writes are taken.
// A new item is accepted while the previous result waits under result_stall.
module led_frame_receiver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  lfr_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output lfr_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lfr_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;

  lfr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  lfr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
  );

endmodule
